/* rtl/core/spm_pkg.sv */
`default_nettype none

package spm_pkg;

  localparam int MAX_TERMS_DEF    = 8;
  localparam int MAX_EXPONENT_DEF = 255;

  localparam int COEF_W  = 16;
  localparam int EXP_W   = 8;
  localparam int PROD_W  = 2 * COEF_W;
  localparam int PCOEF_W = 38;
  localparam int PEXP_W  = 9;

  localparam logic [1:0] OP_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] OP_LOAD_SECOND = 2'd1;
  localparam logic [1:0] OP_MULTIPLY    = 2'd2;

  // One term travelling through or held by the sorting chain.
  typedef struct packed {
    logic                      valid;
    logic [PEXP_W-1:0]         exp;
    logic signed [PCOEF_W-1:0] coef;
  } term_t;

endpackage

`default_nettype wire

/* rtl/core/spm_cell.sv */
`default_nettype none

module spm_cell
  import spm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  shift,
  input  term_t in_term,
  input  term_t next_held,
  output term_t held,
  output term_t pass
);

  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid <= 1'b0;
      pass.valid <= 1'b0;
    end else if (shift) begin
      // output mode: advance the whole row toward the head
      held       <= next_held;
      pass.valid <= 1'b0;
    end else if (in_term.valid) begin
      if (!held.valid) begin
        held       <= in_term;
        pass.valid <= 1'b0;
      end else if (in_term.exp == held.exp) begin
        held.coef  <= held.coef + in_term.coef;
        pass.valid <= 1'b0;
      end else if (in_term.exp > held.exp) begin
        // keep the larger exponent, hand the old one down
        held <= in_term;
        pass <= held;
      end else begin
        pass <= in_term;
      end
    end else begin
      pass.valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/sparse_polynomial_multiply.sv */
`default_nettype none

// Sparse polynomial multiplier. Load terms of the two operands with operation
// 0 and 1 (up to MAX_TERMS per operand; extra terms are dropped and reported
// on load_overflow). Operation 2 walks all loaded term pairs, one product per
// cycle, through a registered multiplier into a row of MAX_TERMS*MAX_TERMS
// sorting cells that merge like exponents and keep them in descending order.
// After the pair walk the row is left to settle, then result words come out
// one per cycle while result_stall is low. Results come out highest exponent
// first; a product with no terms gives one word with empty_result set. Both
// operands and the overflow flag are cleared after the last word.
// item_stall is high for the whole multiply. Operation 3 is ignored.

module sparse_polynomial_multiply
  import spm_pkg::*;
#(
  parameter int MAX_TERMS    = MAX_TERMS_DEF,
  parameter int MAX_EXPONENT = MAX_EXPONENT_DEF
)
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic [1:0]                operation,
  input  logic signed [COEF_W-1:0]  coefficient,
  input  logic [EXP_W-1:0]          exponent,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic signed [PCOEF_W-1:0] product_coefficient,
  output logic [PEXP_W-1:0]         product_exponent,
  output logic                      last_term,
  output logic                      empty_result,
  output logic                      load_overflow
);

  localparam int NCELLS    = MAX_TERMS * MAX_TERMS;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int DRAIN_LEN = NCELLS + 3;
  localparam int DRN_W     = $clog2(DRAIN_LEN + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0] state;

  logic signed [COEF_W-1:0] first_coef  [MAX_TERMS];
  logic [EXP_W-1:0]         first_exp   [MAX_TERMS];
  logic signed [COEF_W-1:0] second_coef [MAX_TERMS];
  logic [EXP_W-1:0]         second_exp  [MAX_TERMS];
  logic [CNT_W-1:0]         first_count;
  logic [CNT_W-1:0]         second_count;
  logic                     overflow_flag;

  logic [IDX_W-1:0] i_idx;
  logic [IDX_W-1:0] j_idx;
  logic [DRN_W-1:0] drain_cnt;

  logic                     s1_valid;
  logic signed [COEF_W-1:0] s1_a;
  logic signed [COEF_W-1:0] s1_b;
  logic [PEXP_W-1:0]        s1_exp;
  logic                     s2_valid;
  logic signed [PROD_W-1:0] s2_prod;
  logic [PEXP_W-1:0]        s2_exp;

  logic [EXP_W-1:0] sat_exp;
  logic             item_take;
  logic             result_take;
  logic             last_j;
  logic             last_i;
  logic             is_last;

  term_t inject;
  term_t heads  [NCELLS+1];
  term_t passes [NCELLS+1];

  assign item_stall   = (state != ST_IDLE);
  assign item_take    = item_valid && !item_stall;
  assign result_valid = (state == ST_EMIT);
  assign result_take  = result_valid && !result_stall;

  assign sat_exp = (32'(exponent) > MAX_EXPONENT) ? EXP_W'(MAX_EXPONENT) : exponent;

  assign last_j = (CNT_W'(j_idx) + CNT_W'(1)) == second_count;
  assign last_i = (CNT_W'(i_idx) + CNT_W'(1)) == first_count;

  // Operand stores and control
  always_ff @(posedge clk) begin
    if (item_take && operation == OP_LOAD_FIRST && first_count < CNT_W'(MAX_TERMS)) begin
      first_coef[first_count[IDX_W-1:0]] <= coefficient;
      first_exp[first_count[IDX_W-1:0]]  <= sat_exp;
    end
    if (item_take && operation == OP_LOAD_SECOND && second_count < CNT_W'(MAX_TERMS)) begin
      second_coef[second_count[IDX_W-1:0]] <= coefficient;
      second_exp[second_count[IDX_W-1:0]]  <= sat_exp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      first_count   <= '0;
      second_count  <= '0;
      overflow_flag <= 1'b0;
      i_idx         <= '0;
      j_idx         <= '0;
      drain_cnt     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (item_take) begin
            case (operation)
              OP_LOAD_FIRST: begin
                if (first_count < CNT_W'(MAX_TERMS)) begin
                  first_count <= first_count + CNT_W'(1);
                end else begin
                  overflow_flag <= 1'b1;
                end
              end
              OP_LOAD_SECOND: begin
                if (second_count < CNT_W'(MAX_TERMS)) begin
                  second_count <= second_count + CNT_W'(1);
                end else begin
                  overflow_flag <= 1'b1;
                end
              end
              OP_MULTIPLY: begin
                i_idx <= '0;
                j_idx <= '0;
                if (first_count == '0 || second_count == '0) begin
                  state     <= ST_DRAIN;
                  drain_cnt <= DRN_W'(DRAIN_LEN);
                end else begin
                  state <= ST_WALK;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_WALK: begin
          if (last_j) begin
            j_idx <= '0;
            if (last_i) begin
              state     <= ST_DRAIN;
              drain_cnt <= DRN_W'(DRAIN_LEN);
            end else begin
              i_idx <= i_idx + IDX_W'(1);
            end
          end else begin
            j_idx <= j_idx + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          if (drain_cnt == '0) begin
            state <= ST_EMIT;
          end else begin
            drain_cnt <= drain_cnt - DRN_W'(1);
          end
        end
        ST_EMIT: begin
          if (result_take && is_last) begin
            state         <= ST_IDLE;
            first_count   <= '0;
            second_count  <= '0;
            overflow_flag <= 1'b0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Product pipeline: read pair, multiply, inject
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= (state == ST_WALK);
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_a    <= first_coef[i_idx];
    s1_b    <= second_coef[j_idx];
    s1_exp  <= PEXP_W'(first_exp[i_idx]) + PEXP_W'(second_exp[j_idx]);
    s2_prod <= s1_a * s1_b;
    s2_exp  <= s1_exp;
  end

  // drop zero products
  assign inject.valid = s2_valid && (s2_prod != '0);
  assign inject.exp   = s2_exp;
  assign inject.coef  = PCOEF_W'(s2_prod);

  assign passes[0]      = inject;
  assign heads[NCELLS]  = '0;

  for (genvar k = 0; k < NCELLS; k++) begin : g_cell
    spm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (result_take),
      .in_term   (passes[k]),
      .next_held (heads[k+1]),
      .held      (heads[k]),
      .pass      (passes[k+1])
    );
  end

  assign is_last = !heads[0].valid || !heads[1].valid;

  always_comb begin
    if (heads[0].valid) begin
      product_coefficient = heads[0].coef;
      product_exponent    = heads[0].exp;
      last_term           = !heads[1].valid;
      empty_result        = 1'b0;
    end else begin
      product_coefficient = '0;
      product_exponent    = '0;
      last_term           = 1'b0;
      empty_result        = 1'b1;
    end
  end

  assign load_overflow = overflow_flag;

endmodule

`default_nettype wire
